### hw/rtl/weekly_alarm_match_scanner_unit_defines.svh
// assertion macros used by the checker file of the alarm scanner
// depends on nothing; included by bare file name
`ifndef WEEKLY_ALARM_MATCH_SCANNER_UNIT_DEFINES_SVH
`define WEEKLY_ALARM_MATCH_SCANNER_UNIT_DEFINES_SVH

// antecedent in this cycle, consequent in the same cycle, off during reset
`define WAMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm scanner check failed");

// antecedent in this cycle, consequent in the next cycle, off during reset
`define WAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm scanner check failed");

// antecedent in this cycle, consequent in the next cycle, also during reset
`define WAMS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("alarm scanner check failed");

`endif

### hw/rtl/wams_pkg.sv
// types, constants and step functions of the weekly alarm match scanner
// depends on nothing; imported by every module of the block
package wams_pkg;

    localparam int MAX_ALARMS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam int EPOCH_W        = 63;
    localparam int DVD_W          = 64;
    localparam int DIGIT_W        = 4;
    localparam int DIV_STEPS      = DVD_W / DIGIT_W;
    localparam int HOUR_STEPS     = 3;
    localparam int CNT_W          = $clog2(DIV_STEPS);
    localparam int ACC_W          = 11;
    localparam int MINUTE_NO_W    = 58;
    localparam int REM_W          = 6;
    localparam int HOUR_W         = 5;
    localparam int IDX_OUT_W      = 4;
    localparam int SEC_PER_MIN    = 60;
    localparam int MIN_PER_DAY    = 1440;
    localparam logic [2:0] DAY_LAST = 3'd6;

    typedef enum logic [1:0] {
        ST_DUE     = 2'd0,
        ST_NONE    = 2'd1,
        ST_BADDAY  = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_CHECK = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SPLIT_LD,
        S_SPLIT,
        S_SCAN,
        S_POST
    } t_wams_state;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [6:0] weekdays;
        logic       enabled;
    } t_alarm_entry;

    typedef struct packed {
        logic load;
        logic split;
        logic step;
    } t_div_ctrl;

    // four bits of long division by 60: returns {remainder, quotient digit}
    function automatic logic [REM_W+DIGIT_W-1:0] div60_step(input logic [REM_W-1:0] rem,
                                                           input logic [DIGIT_W-1:0] dig);
        logic [REM_W:0]   r;
        logic [REM_W-1:0] rr;
        logic [DIGIT_W-1:0] q;
        int k;
        rr = rem;
        q  = '0;
        for (k = DIGIT_W - 1; k >= 0; k--) begin
            r = {rr, dig[k]};
            if (r >= (REM_W+1)'(SEC_PER_MIN)) begin
                q[k] = 1'b1;
                rr   = REM_W'(r - (REM_W+1)'(SEC_PER_MIN));
            end else begin
                rr   = r[REM_W-1:0];
            end
        end
        return {rr, q};
    endfunction

    // running quotient modulo minutes per day, four quotient bits at a time
    function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                  input logic [DIGIT_W-1:0] q);
        logic [ACC_W:0]   a;
        logic [ACC_W-1:0] aa;
        int k;
        aa = acc;
        for (k = DIGIT_W - 1; k >= 0; k--) begin
            a = {aa, q[k]};
            if (a >= (ACC_W+1)'(MIN_PER_DAY)) begin
                aa = ACC_W'(a - (ACC_W+1)'(MIN_PER_DAY));
            end else begin
                aa = a[ACC_W-1:0];
            end
        end
        return aa;
    endfunction

endpackage

### hw/rtl/weekly_alarm_match_scanner_unit.sv
// top level of the weekly alarm match scanner: alarm table, scan sequencer, output register
// depends on wams_pkg and wams_div60
//
// The block keeps a table of MAX_ALARMS alarm entries and answers one result item per
// input item. A write item (tuser 0) loads one table slot and offers "entry written"
// by way of S_POST and the output register once it is taken. A check item (tuser 1)
// brings epoch seconds and a weekday; a weekday above 6 offers "bad weekday" the same
// way, otherwise the shared divide-by-60 unit splits the time into minute number, hour
// and minute (16 steps of four bits, one load, three more steps), and then the table is
// read one entry per cycle from slot 0 up to the active count N. The first entry that
// is enabled, matches the weekday mask, hour and minute and has not fired in this
// minute is reported and marked fired. A check item's result waits on the divider
// steps and the single table read port.
// The input is not ready while an item is being worked on; a finished
// result sits in an output register so the next item can be taken while it waits.
// Configuration writes to alarm_count may be made at any idle time; values above
// MAX_ALARMS act as MAX_ALARMS. Table slots need a write before they are checked.
module weekly_alarm_match_scanner_unit
    import wams_pkg::*;
#(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input item channel
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // entry_index[3:0], entry_enabled[4], entry_weekdays[11:5], entry_hour[16:12],
    // entry_minute[22:17], now_epoch_s[85:23], weekday[88:86], zero fill[95:89]
    input  logic [95:0]      i_s_tdata,
    // kind[0]
    input  logic             i_s_tuser,
    // result item channel
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // alarm_index[3:0], zero fill[7:4]
    output logic [7:0]       o_m_tdata,
    // status[1:0]
    output logic [1:0]       o_m_tuser,
    // alarm_count register
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    localparam int AW   = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int IDXW = $clog2(MAX_ALARMS + 1);
    localparam int CW   = (IDXW > CFG_W) ? IDXW : CFG_W;

    // input item fields
    logic [3:0]         w_in_index;
    t_alarm_entry       w_in_entry;
    logic [EPOCH_W-1:0] w_in_epoch;
    logic [2:0]         w_in_day;
    logic               w_in_kind;
    logic               w_accept;

    assign w_in_index          = i_s_tdata[3:0];
    assign w_in_entry.enabled  = i_s_tdata[4];
    assign w_in_entry.weekdays = i_s_tdata[11:5];
    assign w_in_entry.hour     = i_s_tdata[16:12];
    assign w_in_entry.minute   = i_s_tdata[22:17];
    assign w_in_epoch          = i_s_tdata[85:23];
    assign w_in_day            = i_s_tdata[88:86];
    assign w_in_kind           = i_s_tuser;

    // control state
    t_wams_state        r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CFG_W-1:0]   r_alarm_count;
    logic [CW-1:0]      r_scan;
    logic               r_pend;
    logic [MAX_ALARMS-1:0] r_lf_vld;
    logic               r_out_vld;

    // payload state
    logic [2:0]         r_day;
    logic [MINUTE_NO_W-1:0] r_min_no;
    logic [CW-1:0]      r_pidx;
    t_alarm_entry       r_ent_q;
    logic [MINUTE_NO_W-1:0] r_lf_q;
    logic               r_lf_vld_q;
    t_status            r_res_status, n_res_status;
    logic [IDX_OUT_W-1:0] r_res_idx, n_res_idx;
    t_status            r_out_status;
    logic [IDX_OUT_W-1:0] r_out_idx;

    // table and last-fire memories
    t_alarm_entry           r_entries [MAX_ALARMS];
    logic [MINUTE_NO_W-1:0] r_lf_mem  [MAX_ALARMS];

    // sequencer outputs
    t_div_ctrl          w_ctrl;
    logic               w_ready;
    logic               w_issue;
    logic               w_hit;
    logic               w_out_load;
    logic               w_wr_ent;

    // divider results
    logic [DVD_W-1:0]   w_quo;
    logic [REM_W-1:0]   w_rem;

    // active entry count, saturated at the table depth
    logic [CW-1:0]      w_cnt_ext;
    logic [CW-1:0]      w_active;
    logic               w_match;

    assign w_cnt_ext = CW'(r_alarm_count);
    assign w_active  = (w_cnt_ext > CW'(MAX_ALARMS)) ? CW'(MAX_ALARMS) : w_cnt_ext;

    assign w_accept  = i_s_tvalid && w_ready;
    assign w_wr_ent  = w_accept && (w_in_kind == KIND_WRITE)
                       && (CW'(w_in_index) < CW'(MAX_ALARMS));

    // candidate entry held in r_ent_q against the current time
    assign w_match = r_ent_q.enabled
                     && ((r_ent_q.weekdays == '0) || r_ent_q.weekdays[r_day])
                     && (r_ent_q.hour == w_quo[HOUR_W-1:0])
                     && (r_ent_q.minute == w_rem)
                     && !(r_lf_vld_q && (r_lf_q == r_min_no));

    wams_div60 u_div (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_epoch (w_in_epoch),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        w_ctrl       = '0;
        w_ready      = 1'b0;
        w_issue      = 1'b0;
        w_hit        = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                n_cnt   = '0;
                if (i_s_tvalid) begin
                    if (w_in_kind == KIND_WRITE) begin
                        n_res_status = ST_WRITTEN;
                        n_res_idx    = '0;
                        n_state      = S_POST;
                    end else if (w_in_day > DAY_LAST) begin
                        n_res_status = ST_BADDAY;
                        n_res_idx    = '0;
                        n_state      = S_POST;
                    end else begin
                        w_ctrl.load = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // epoch / 60 and its value modulo minutes per day
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SPLIT_LD;
                end
            end
            S_SPLIT_LD: begin
                w_ctrl.load  = 1'b1;
                w_ctrl.split = 1'b1;
                n_cnt        = '0;
                n_state      = S_SPLIT;
            end
            S_SPLIT: begin
                // minute of day / 60 gives hour and minute
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HOUR_STEPS - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // one table read per cycle, candidate checked in the cycle after its read
                w_hit   = r_pend && w_match;
                w_issue = !w_hit && (r_scan < w_active);
                if (w_hit) begin
                    n_res_status = ST_DUE;
                    n_res_idx    = IDX_OUT_W'(r_pidx);
                    n_state      = S_POST;
                end else if (!r_pend && !w_issue) begin
                    n_res_status = ST_NONE;
                    n_res_idx    = '0;
                    n_state      = S_POST;
                end
            end
            S_POST: begin
                if (!r_out_vld || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_alarm_count <= '0;
            r_scan        <= '0;
            r_pend        <= 1'b0;
            r_lf_vld      <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_alarm_count <= i_cfg_wr_data;
            end
            if (r_state == S_SPLIT) begin
                r_scan <= '0;
                r_pend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (w_hit) begin
                r_lf_vld[r_pidx[AW-1:0]] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        if (w_accept) begin
            r_day <= w_in_day;
        end
        if (r_state == S_SPLIT_LD) begin
            r_min_no <= w_quo[MINUTE_NO_W-1:0];
        end
        if (w_issue) begin
            r_pidx     <= r_scan;
            r_lf_vld_q <= r_lf_vld[r_scan[AW-1:0]];
        end
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
        end
    end

    // alarm table: written by write items, read by the scan
    always_ff @(posedge i_clk) begin
        if (w_wr_ent) begin
            r_entries[AW'(w_in_index)] <= w_in_entry;
        end
        if (w_issue) begin
            r_ent_q <= r_entries[r_scan[AW-1:0]];
        end
    end

    // last fire minute per entry, valid bits above stand for the reset value
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_lf_mem[r_pidx[AW-1:0]] <= r_min_no;
        end
        if (w_issue) begin
            r_lf_q <= r_lf_mem[r_scan[AW-1:0]];
        end
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(8-IDX_OUT_W){1'b0}}, r_out_idx};
    assign o_m_tuser  = r_out_status;

endmodule

### hw/rtl/wams_div60.sv
// shared divide-by-60 unit, four dividend bits per step
// depends on wams_pkg
module wams_div60
    import wams_pkg::*;
(
    input  logic               i_clk,
    input  t_div_ctrl          i_ctrl,
    input  logic [EPOCH_W-1:0] i_epoch,
    output logic [DVD_W-1:0]   o_quo,
    output logic [REM_W-1:0]   o_rem
);

    logic [DVD_W-1:0]   r_dvd;
    logic [DVD_W-1:0]   r_quo;
    logic [REM_W-1:0]   r_rem;
    logic [ACC_W-1:0]   r_acc;
    logic [REM_W-1:0]   w_rem;
    logic [DIGIT_W-1:0] w_q;

    assign {w_rem, w_q} = div60_step(r_rem, r_dvd[DVD_W-1 -: DIGIT_W]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            // split pass divides the minute of day to get hour and minute
            r_dvd <= i_ctrl.split ? {1'b0, r_acc, {(DVD_W-ACC_W-1){1'b0}}}
                                  : {1'b0, i_epoch};
            r_quo <= '0;
            r_rem <= '0;
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            r_dvd <= {r_dvd[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_quo <= {r_quo[DVD_W-DIGIT_W-1:0], w_q};
            r_rem <= w_rem;
            r_acc <= acc_step(r_acc, w_q);
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

### hw/rtl/wams_checker.sv
// port-level checks of the weekly alarm match scanner, bound to the top level
// depends on wams_pkg and weekly_alarm_match_scanner_unit_defines.svh
`include "weekly_alarm_match_scanner_unit_defines.svh"

module wams_checker
    import wams_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic [95:0]      i_s_tdata,
    input logic             i_s_tuser,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [7:0]       o_m_tdata,
    input logic [1:0]       o_m_tuser,
    input logic             i_cfg_wr_en,
    input logic [CFG_W-1:0] i_cfg_wr_data
);

    logic w_unused;
    assign w_unused = ^{i_s_tdata, i_s_tuser, i_cfg_wr_en, i_cfg_wr_data};

    // a stalled result holds
    `WAMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // alarm index is zero unless an alarm is due
    `WAMS_ASSERT_SAME(a_idx_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_DUE), o_m_tdata == 8'd0)

    // one item at a time: busy right after taking an item
    `WAMS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // reset leaves no result pending and the input open
    `WAMS_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !o_m_tvalid && o_s_tready)

endmodule

bind weekly_alarm_match_scanner_unit wams_checker u_wams_checker (.*);
